// ===== hdl/dcof_pkg.sv =====
package dcof_pkg;

  localparam logic [1:0] OP_WMEM   = 2'd0;
  localparam logic [1:0] OP_WREG   = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic [15:0] REG_SP = 16'd8;
  localparam logic [15:0] REG_PC = 16'd9;
  localparam logic [15:0] REG_EX = 16'd10;
  localparam logic [15:0] REG_GEN_LAST = 16'd7;

  localparam logic [2:0] KIND_GEN = 3'd0;
  localparam logic [2:0] KIND_MEM = 3'd1;
  localparam logic [2:0] KIND_SP  = 3'd2;
  localparam logic [2:0] KIND_PC  = 3'd3;
  localparam logic [2:0] KIND_EX  = 3'd4;
  localparam logic [2:0] KIND_LIT = 3'd5;

  localparam logic [5:0] MODE_REG_LAST    = 6'h07;
  localparam logic [5:0] MODE_IND_FIRST   = 6'h08;
  localparam logic [5:0] MODE_IND_LAST    = 6'h0f;
  localparam logic [5:0] MODE_OFS_FIRST   = 6'h10;
  localparam logic [5:0] MODE_OFS_LAST    = 6'h17;
  localparam logic [5:0] MODE_PUSHPOP     = 6'h18;
  localparam logic [5:0] MODE_PEEK        = 6'h19;
  localparam logic [5:0] MODE_SP_NW       = 6'h1a;
  localparam logic [5:0] MODE_SP          = 6'h1b;
  localparam logic [5:0] MODE_PC          = 6'h1c;
  localparam logic [5:0] MODE_EX          = 6'h1d;
  localparam logic [5:0] MODE_NW_ADDR     = 6'h1e;
  localparam logic [5:0] MODE_NW_LIT      = 6'h1f;

  localparam logic [15:0] LIT_BIAS = 16'h0021;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INST,
    ST_RES,
    ST_NEXT,
    ST_RDA,
    ST_RDB,
    ST_CAPB
  } state_t;

  typedef struct packed {
    logic        gen_en;
    logic [2:0]  gen_idx;
    logic [15:0] gen_data;
    logic        sp_en;
    logic [15:0] sp_data;
    logic        pc_en;
    logic [15:0] pc_data;
    logic        ex_en;
    logic [15:0] ex_data;
  } regs_wr_t;

endpackage

// ===== hdl/dcof_mem.sv =====
module dcof_mem
  import dcof_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        we,
  input  logic [15:0] addr,
  input  logic [15:0] wdata,
  output logic [15:0] rdata
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] mem [MEM_WORDS];
  logic [23:0] red;
  logic [AW-1:0] idx;

  // reduce address modulo the memory size; quotient stays below 256
  always_comb begin
    red = {8'd0, addr};
    for (int k = 7; k >= 0; k--) begin
      if (red >= (24'(MEM_WORDS) << k)) begin
        red = red - (24'(MEM_WORDS) << k);
      end
    end
    idx = red[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    rdata <= mem[idx];
  end

endmodule

// ===== hdl/dcof_regs.sv =====
module dcof_regs
  import dcof_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  regs_wr_t    wr,
  input  logic [2:0]  rd_idx,
  output logic [15:0] gen_rd,
  output logic [15:0] sp,
  output logic [15:0] pc,
  output logic [15:0] ex
);

  logic [15:0] gen [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        gen[i] <= '0;
      end
      sp <= '0;
      pc <= '0;
      ex <= '0;
    end else begin
      if (wr.gen_en) begin
        gen[wr.gen_idx] <= wr.gen_data;
      end
      if (wr.sp_en) begin
        sp <= wr.sp_data;
      end
      if (wr.pc_en) begin
        pc <= wr.pc_data;
      end
      if (wr.ex_en) begin
        ex <= wr.ex_data;
      end
    end
  end

  assign gen_rd = gen[rd_idx];

endmodule

// ===== hdl/dcpu16_operand_fetch_decode.sv =====
// Register and memory writes are taken while idle; busy stays low.
// A decode request steps INST, RES per operand (then NEXT on a next-word read),
// RDA, RDB, CAPB; done is registered from CAPB; busy is high until the strobe.
// The single port of the main memory serializes fetch, next words and values.
// The receiver cannot stall. Reset clears GP registers, SP, PC, EX and control;
// memory contents are undefined until written.
module dcpu16_operand_fetch_decode
  import dcof_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [15:0] address,
  input  logic [15:0] data,
  output logic        done,
  output logic [4:0]  instr_op,
  output logic [2:0]  a_kind,
  output logic [15:0] a_where,
  output logic [15:0] a_value,
  output logic [2:0]  b_kind,
  output logic [15:0] b_where,
  output logic [15:0] b_value,
  output logic [15:0] pc_after,
  output logic [15:0] sp_after
);

  state_t      state, state_next;
  logic        side;
  logic [15:0] inst;

  logic        mem_we;
  logic [15:0] mem_addr;
  logic [15:0] mem_rdata;

  regs_wr_t    wr;
  logic [2:0]  rd_idx;
  logic [15:0] gen_rd, sp, pc, ex;

  logic        accept;
  logic [5:0]  f;
  logic [15:0] lit;
  logic [2:0]  r_kind;
  logic [15:0] r_where;
  logic        r_nw;
  logic        r_sp_en;
  logic [15:0] r_sp;
  logic        r_pc_en;
  logic [15:0] nw_base;

  dcof_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (data),
    .rdata (mem_rdata)
  );

  dcof_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (rd_idx),
    .gen_rd (gen_rd),
    .sp     (sp),
    .pc     (pc),
    .ex     (ex)
  );

  assign accept   = start && !busy;
  assign f        = side ? {1'b0, inst[9:5]} : inst[15:10];
  assign lit      = {10'd0, inst[15:10]} - LIT_BIAS;
  assign instr_op = inst[4:0];
  assign pc_after = pc;
  assign sp_after = sp;

  always_comb begin
    r_kind  = KIND_MEM;
    r_where = '0;
    r_nw    = 1'b0;
    r_sp_en = 1'b0;
    r_sp    = sp;
    r_pc_en = 1'b0;
    nw_base = '0;
    if (f <= MODE_REG_LAST) begin
      r_kind  = KIND_GEN;
      r_where = {13'd0, f[2:0]};
    end else if (f inside {[MODE_IND_FIRST:MODE_IND_LAST]}) begin
      r_where = gen_rd;
    end else if (f inside {[MODE_OFS_FIRST:MODE_OFS_LAST]}) begin
      r_nw    = 1'b1;
      nw_base = gen_rd;
    end else begin
      case (f)
        MODE_PUSHPOP: begin
          r_sp_en = 1'b1;
          if (side) begin
            r_sp    = sp - 16'd1;
            r_where = sp - 16'd1;
          end else begin
            r_sp    = sp + 16'd1;
            r_where = sp;
          end
        end
        MODE_PEEK:    r_where = sp;
        MODE_SP_NW: begin
          r_nw    = 1'b1;
          nw_base = sp;
        end
        MODE_SP:      r_kind = KIND_SP;
        MODE_PC:      r_kind = KIND_PC;
        MODE_EX:      r_kind = KIND_EX;
        MODE_NW_ADDR: r_nw = 1'b1;
        MODE_NW_LIT: begin
          r_where = pc;
          r_pc_en = 1'b1;
        end
        default:      r_kind = KIND_LIT;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_DECODE) begin
          state_next = ST_INST;
        end
      end
      ST_INST: state_next = ST_RES;
      ST_RES: begin
        if (r_nw) begin
          state_next = ST_NEXT;
        end else begin
          state_next = side ? ST_RDA : ST_RES;
        end
      end
      ST_NEXT: state_next = side ? ST_RDA : ST_RES;
      ST_RDA:  state_next = ST_RDB;
      ST_RDB:  state_next = ST_CAPB;
      ST_CAPB: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    mem_we   = 1'b0;
    mem_addr = pc;
    rd_idx   = f[2:0];
    wr       = '0;
    wr.gen_idx  = address[2:0];
    wr.gen_data = data;
    wr.sp_data  = data;
    wr.pc_data  = data;
    wr.ex_data  = data;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept && opcode == OP_WMEM) begin
          mem_we   = 1'b1;
          mem_addr = address;
        end
        if (accept && opcode == OP_WREG) begin
          wr.gen_en = address <= REG_GEN_LAST;
          wr.sp_en  = address == REG_SP;
          wr.pc_en  = address == REG_PC;
          wr.ex_en  = address == REG_EX;
        end
        if (accept && opcode == OP_DECODE) begin
          wr.pc_en   = 1'b1;
          wr.pc_data = pc + 16'd1;
        end
      end
      ST_RES: begin
        wr.sp_en   = r_sp_en;
        wr.sp_data = r_sp;
        wr.pc_en   = r_pc_en || r_nw;
        wr.pc_data = pc + 16'd1;
      end
      ST_RDA:  mem_addr = a_where;
      ST_RDB: begin
        mem_addr = b_where;
        rd_idx   = a_where[2:0];
      end
      ST_CAPB: rd_idx = b_where[2:0];
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      side  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == ST_CAPB;
      if (state == ST_INST) begin
        side <= 1'b0;
      end else if ((state == ST_RES && !r_nw) || state == ST_NEXT) begin
        side <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_INST) begin
      inst <= mem_rdata;
    end
    if (state == ST_RES && !r_nw) begin
      if (side) begin
        b_kind  <= r_kind;
        b_where <= r_where;
      end else begin
        a_kind  <= r_kind;
        a_where <= r_where;
      end
    end
    if (state == ST_NEXT) begin
      if (side) begin
        b_kind  <= KIND_MEM;
        b_where <= nw_base + mem_rdata;
      end else begin
        a_kind  <= KIND_MEM;
        a_where <= nw_base + mem_rdata;
      end
    end
    if (state == ST_RDB) begin
      case (a_kind)
        KIND_GEN: a_value <= gen_rd;
        KIND_MEM: a_value <= mem_rdata;
        KIND_SP:  a_value <= sp;
        KIND_PC:  a_value <= pc;
        KIND_EX:  a_value <= ex;
        default:  a_value <= lit;
      endcase
    end
    if (state == ST_CAPB) begin
      case (b_kind)
        KIND_GEN: b_value <= gen_rd;
        KIND_MEM: b_value <= mem_rdata;
        KIND_SP:  b_value <= sp;
        KIND_PC:  b_value <= pc;
        default:  b_value <= ex;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_capture: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_CAPB))
    else $error("result strobe without a finished decode");

  a_decode_holds_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_DECODE) |=> busy)
    else $error("decode request did not raise busy");

  a_kinds_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (a_kind <= KIND_LIT && b_kind <= KIND_EX))
    else $error("operand kind out of range on result");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !mem_we)
    else $error("memory write during decode");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dcof_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [4:0]  instr_op;
    logic [2:0]  a_kind;
    logic [15:0] a_where;
    logic [15:0] a_value;
    logic [2:0]  b_kind;
    logic [15:0] b_where;
    logic [15:0] b_value;
    logic [15:0] pc_after;
    logic [15:0] sp_after;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = OP_WMEM;
  logic [15:0] address = '0;
  logic [15:0] data = '0;
  logic        busy;
  logic        done;
  logic [4:0]  instr_op;
  logic [2:0]  a_kind;
  logic [15:0] a_where;
  logic [15:0] a_value;
  logic [2:0]  b_kind;
  logic [15:0] b_where;
  logic [15:0] b_value;
  logic [15:0] pc_after;
  logic [15:0] sp_after;

  logic [15:0] gen_reg [8];
  logic [15:0] sp_reg;
  logic [15:0] pc_reg;
  logic [15:0] ex_reg;
  bit   [15:0] mem_word [65536];
  bit          mem_written [65536];
  int          miss_addr;

  decode_result_t pending_decodes [$];
  bit steady;
  bit seen_a [64];
  bit seen_b [32];
  int n_items;
  int n_decodes;
  int n_mem_writes;
  int n_reg_writes;
  int n_ignored;
  int mismatches;
  int quiet_cycles;

  always #2 clk = ~clk;

  dcpu16_operand_fetch_decode u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .address  (address),
    .data     (data),
    .done     (done),
    .instr_op (instr_op),
    .a_kind   (a_kind),
    .a_where  (a_where),
    .a_value  (a_value),
    .b_kind   (b_kind),
    .b_where  (b_where),
    .b_value  (b_value),
    .pc_after (pc_after),
    .sp_after (sp_after)
  );

  function automatic logic [15:0] mem_fetch(logic [15:0] addr);
    if (!mem_written[addr] && miss_addr < 0) miss_addr = addr;
    return mem_word[addr];
  endfunction

  function automatic logic [15:0] next_word();
    logic [15:0] w;
    w = mem_fetch(pc_reg);
    pc_reg = pc_reg + 16'd1;
    return w;
  endfunction

  function automatic void resolve_operand(input logic [5:0] f, input bit is_b,
                                          output logic [2:0] kind,
                                          output logic [15:0] where,
                                          output logic [15:0] lit);
    logic [15:0] base;
    kind = KIND_MEM;
    where = '0;
    lit = '0;
    if (f <= MODE_REG_LAST) begin
      kind = KIND_GEN;
      where = {13'd0, f[2:0]};
    end else if (f <= MODE_IND_LAST) begin
      where = gen_reg[f[2:0]];
    end else if (f <= MODE_OFS_LAST) begin
      base = gen_reg[f[2:0]];
      where = base + next_word();
    end else if (f == MODE_PUSHPOP) begin
      if (is_b) begin
        sp_reg = sp_reg - 16'd1;
        where = sp_reg;
      end else begin
        where = sp_reg;
        sp_reg = sp_reg + 16'd1;
      end
    end else if (f == MODE_PEEK) begin
      where = sp_reg;
    end else if (f == MODE_SP_NW) begin
      base = sp_reg;
      where = base + next_word();
    end else if (f == MODE_SP) begin
      kind = KIND_SP;
    end else if (f == MODE_PC) begin
      kind = KIND_PC;
    end else if (f == MODE_EX) begin
      kind = KIND_EX;
    end else if (f == MODE_NW_ADDR) begin
      where = next_word();
    end else if (f == MODE_NW_LIT) begin
      where = pc_reg;
      pc_reg = pc_reg + 16'd1;
    end else begin
      kind = KIND_LIT;
      lit = {10'd0, f} - LIT_BIAS;
    end
  endfunction

  function automatic logic [15:0] operand_value(logic [2:0] kind, logic [15:0] where,
                                                logic [15:0] lit);
    case (kind)
      KIND_GEN: return gen_reg[where[2:0]];
      KIND_MEM: return mem_fetch(where);
      KIND_SP:  return sp_reg;
      KIND_PC:  return pc_reg;
      KIND_EX:  return ex_reg;
      default:  return lit;
    endcase
  endfunction

  // Return 1 when every memory word the decode touches has been written.
  function automatic bit predict_decode(input bit commit, output decode_result_t r);
    logic [15:0] gen_save [8];
    logic [15:0] sp_save;
    logic [15:0] pc_save;
    logic [15:0] inst;
    logic [15:0] lit_a;
    logic [15:0] lit_b;
    gen_save = gen_reg;
    sp_save = sp_reg;
    pc_save = pc_reg;
    miss_addr = -1;
    inst = next_word();
    r.instr_op = inst[4:0];
    resolve_operand(inst[15:10], 1'b0, r.a_kind, r.a_where, lit_a);
    resolve_operand({1'b0, inst[9:5]}, 1'b1, r.b_kind, r.b_where, lit_b);
    r.a_value = operand_value(r.a_kind, r.a_where, lit_a);
    r.b_value = operand_value(r.b_kind, r.b_where, lit_b);
    r.pc_after = pc_reg;
    r.sp_after = sp_reg;
    if (commit) begin
      seen_a[inst[15:10]] = 1'b1;
      seen_b[inst[9:5]] = 1'b1;
    end else begin
      gen_reg = gen_save;
      sp_reg = sp_save;
      pc_reg = pc_save;
    end
    return miss_addr < 0;
  endfunction

  function automatic void apply_request(logic [1:0] op, logic [15:0] addr,
                                        logic [15:0] dat);
    decode_result_t r;
    case (op)
      OP_WMEM: begin
        mem_word[addr] = dat;
        mem_written[addr] = 1'b1;
        n_mem_writes++;
      end
      OP_WREG: begin
        n_reg_writes++;
        if (addr <= REG_GEN_LAST) gen_reg[addr[2:0]] = dat;
        else if (addr == REG_SP) sp_reg = dat;
        else if (addr == REG_PC) pc_reg = dat;
        else if (addr == REG_EX) ex_reg = dat;
      end
      OP_DECODE: begin
        void'(predict_decode(1'b1, r));
        pending_decodes.push_back(r);
        n_decodes++;
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    if (r < 40) return 16'($urandom_range(0, 3));
    if (r < 50) return 16'($urandom_range(16'hFFFC, 16'hFFFF));
    return 16'($urandom);
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                              input logic [15:0] dat);
    int gap;
    start <= 1'b1;
    opcode <= op;
    address <= addr;
    data <= dat;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_request(op, addr, dat);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      opcode <= 2'($urandom);
      address <= 16'($urandom);
      data <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Fill any unwritten word the decode would read, then issue it.
  task automatic decode_request();
    decode_result_t probe;
    while (!predict_decode(1'b0, probe))
      send_request(OP_WMEM, 16'(miss_addr), 16'($urandom));
    send_request(OP_DECODE, 16'($urandom), 16'($urandom));
  endtask

  task automatic decode_instruction(input logic [5:0] a_mode, input logic [4:0] b_mode,
                                    input logic [4:0] op);
    send_request(OP_WMEM, pc_reg, {a_mode, b_mode, op});
    decode_request();
  endtask

  task automatic test_register_writes();
    steady = 1'b1;
    send_request(OP_WREG, 16'd0, 16'hFFFF);
    send_request(OP_WREG, REG_GEN_LAST, 16'h8001);
    send_request(OP_WREG, REG_EX, 16'hA5A5);
    send_request(OP_WREG, REG_PC, 16'hFFFE);
    send_request(OP_WREG, REG_SP, 16'hFFFF);
    decode_instruction(MODE_EX, 5'(MODE_IND_LAST), 5'h00);
  endtask

  task automatic test_ignored_requests();
    steady = 1'b0;
    send_request(OP_WREG, REG_EX + 16'd1, 16'h1234);
    send_request(OP_WREG, 16'hFFFF, 16'hFFFF);
    send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_request(OP_UNUSED, 16'h0000, 16'h0000);
    send_request(OP_WMEM, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_stack_wrap();
    send_request(OP_WREG, REG_SP, 16'hFFFF);
    decode_instruction(MODE_PUSHPOP, 5'(MODE_PUSHPOP), 5'h1F);
    send_request(OP_WREG, REG_SP, 16'h0000);
    decode_instruction(MODE_PEEK, 5'(MODE_PUSHPOP), 5'h01);
  endtask

  task automatic test_next_word_modes();
    send_request(OP_WREG, REG_PC, 16'hFFFF);
    decode_instruction(MODE_SP_NW, 5'(MODE_OFS_LAST), 5'h02);
    decode_instruction(MODE_NW_LIT, 5'(MODE_NW_ADDR), 5'h10);
    decode_instruction(MODE_OFS_FIRST, 5'(MODE_SP_NW), 5'h03);
  endtask

  task automatic test_literals();
    steady = 1'b1;
    decode_instruction(6'h20, 5'(MODE_SP), 5'h04);
    decode_instruction(6'h3F, 5'(MODE_PC), 5'h05);
    decode_instruction(6'h21, 5'(MODE_EX), 5'h06);
    decode_instruction(6'h00, 5'(MODE_REG_LAST), 5'h1F);
  endtask

  task automatic test_random_traffic();
    int r;
    int stretch;
    stretch = 0;
    while (n_items < ITEM_TARGET) begin
      if (stretch == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        stretch = 40;
      end
      stretch--;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        decode_request();
      end else if (r < 63) begin
        send_request(OP_WMEM, pick_word(), pick_word());
      end else if (r < 72) begin
        decode_instruction(6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
                           5'($urandom_range(0, 31)));
      end else if (r < 90) begin
        send_request(OP_WREG, 16'($urandom_range(0, REG_EX)), pick_word());
      end else if (r < 95) begin
        send_request(OP_WREG, 16'($urandom_range(REG_EX + 1, 16'hFFFF)), pick_word());
      end else begin
        send_request(OP_UNUSED, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic finish_run();
    int modes_a;
    int modes_b;
    start <= 1'b0;
    while (pending_decodes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    modes_a = 0;
    modes_b = 0;
    foreach (seen_a[i]) modes_a += seen_a[i];
    foreach (seen_b[i]) modes_b += seen_b[i];
    $display("%0d requests: %0d decodes, %0d memory writes, %0d register writes, %0d unused",
             n_items, n_decodes, n_mem_writes, n_reg_writes, n_ignored);
    $display("operand modes exercised: a %0d of 64, b %0d of 32, mismatches %0d",
             modes_a, modes_b, mismatches);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("dcpu16_operand_fetch_decode verification clean");
    end else begin
      $display("dcpu16_operand_fetch_decode verification failed");
    end
    $finish;
  endtask

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (actv !== expv) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, expv, actv);
    end
  endtask

  always @(posedge clk) begin : check_results
    decode_result_t expd;
    if (!rst && done) begin
      if (pending_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: result with no decode pending, instr_op %h", instr_op);
      end else begin
        expd = pending_decodes.pop_front();
        check_field("instr_op", 16'(expd.instr_op), 16'(instr_op));
        check_field("a_kind", 16'(expd.a_kind), 16'(a_kind));
        check_field("a_where", expd.a_where, a_where);
        check_field("a_value", expd.a_value, a_value);
        check_field("b_kind", 16'(expd.b_kind), 16'(b_kind));
        check_field("b_where", expd.b_where, b_where);
        check_field("b_value", expd.b_value, b_value);
        check_field("pc_after", expd.pc_after, pc_after);
        check_field("sp_after", expd.sp_after, sp_after);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dcpu16_operand_fetch_decode verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (gen_reg[i]) gen_reg[i] = '0;
    sp_reg = '0;
    pc_reg = '0;
    ex_reg = '0;
    steady = 1'b0;
    n_items = 0;
    n_decodes = 0;
    n_mem_writes = 0;
    n_reg_writes = 0;
    n_ignored = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_writes();
    test_ignored_requests();
    test_stack_wrap();
    test_next_word_modes();
    test_literals();
    test_random_traffic();
    finish_run();
  end

endmodule
